// ===== hdl/indexed_min_heap_priority_queue_assert.svh =====
// assertion macros for the indexed min-heap priority queue
`ifndef INDEXED_MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define INDEXED_MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
`define IMH_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define IMH_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("assertion failed");
`else
`define IMH_ASSERT(lbl, clk, rst_n, prop)
`define IMH_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ===== hdl/imh_pkg.sv =====
// package for the indexed min-heap priority queue: types, codes and defaults
`timescale 1ns / 1ps
package imh_pkg;
	localparam int CAPACITY_DEF  = 64;
	localparam int NODE_IDS_DEF  = 64;
	localparam int KEY_WIDTH_DEF = 64;

	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_FULL   = 3'd1;
	localparam logic [2:0] ST_EMPTY  = 3'd2;
	localparam logic [2:0] ST_DUP    = 3'd3;
	localparam logic [2:0] ST_ABSENT = 3'd4;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [5:0]  node_id;
		logic [63:0] key;
	} imh_in_t;

	typedef struct packed {
		logic [5:0]  top_node_id;
		logic [63:0] top_key;
		logic        is_empty;
		logic [6:0]  node_count;
		logic [2:0]  status;
	} imh_out_t;

	// datapath commands
	typedef enum logic [3:0] {
		DC_NONE,
		DC_LOAD_IN,     // latch item, read present bit and node_slot
		DC_PUSH_WR,     // write new entry at slot count, count++
		DC_POP_RD,      // read last slot
		DC_POP_WR,      // move last to root, count--
		DC_UPD_RD,      // read entry at mapped slot
		DC_UPD_WR,      // write new key at cur, choose direction
		DC_UP_RD,       // read parent of cur
		DC_UP_SWAP,     // compare with parent and swap
		DC_DN_RD_L,     // read left child
		DC_DN_RD_R,     // read right child
		DC_DN_SWAP,     // choose and swap
		DC_ROOT_RD      // read root for result
	} imh_cmd_t;

	typedef struct packed {
		logic       full;
		logic       empty;
		logic       present;
		logic       id_ok;
		logic       grew;
		logic       up_more;  // cur has a parent
		logic       up_moved; // last up step swapped
		logic       dn_moved; // last down step swapped
		logic       has_left;
		logic       has_right;
		logic [1:0] opcode;
	} imh_sts_t;

	function automatic logic key_less(input logic [63:0] a, input logic [63:0] b);
		key_less = $signed(a) < $signed(b);
	endfunction
endpackage

// ===== hdl/imh_datapath.sv =====
// datapath: heap and map memories, cursor, compare and swap
`timescale 1ns / 1ps
`include "indexed_min_heap_priority_queue_assert.svh"
module imh_datapath #(
	parameter int CAPACITY  = imh_pkg::CAPACITY_DEF,
	parameter int NODE_IDS  = imh_pkg::NODE_IDS_DEF,
	parameter int KEY_WIDTH = imh_pkg::KEY_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  imh_pkg::imh_in_t  in_item,
	input  imh_pkg::imh_cmd_t cmd,
	input  logic [2:0]        set_status,
	input  logic              set_status_en,
	output imh_pkg::imh_sts_t sts,
	output imh_pkg::imh_out_t out_item
);
	import imh_pkg::*;
	localparam int SW = $clog2(CAPACITY);
	localparam int NW = $clog2(NODE_IDS);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [NW-1:0]      slot_node [CAPACITY];
	logic [63:0]        slot_key  [CAPACITY];
	logic [SW-1:0]      node_slot [NODE_IDS];
	logic [NODE_IDS-1:0] present_q;
	logic [CW-1:0]      count_q;

	logic [1:0]    op_q;
	logic [5:0]    id_q;
	logic [63:0]   key_q;
	logic          id_ok_q;
	logic          pres_q;
	logic [SW-1:0] map_q;   // node_slot read
	logic [SW-1:0] cur_q;   // slot of moving entry
	logic [NW-1:0] cur_n_q;
	logic [63:0]   cur_k_q;
	logic [SW-1:0] oth_q;   // slot of compared entry
	logic [NW-1:0] oth_n_q;
	logic [63:0]   oth_k_q;
	logic [SW-1:0] r_q;
	logic [NW-1:0] r_n_q;
	logic [63:0]   r_k_q;
	logic          up_mv_q, dn_mv_q;
	logic [2:0]    status_q;
	logic [NW-1:0] rt_n_q;
	logic [63:0]   rt_k_q;

	// widened input key
	logic [63:0] wkey;
	assign wkey = 64'($signed(in_item.key[KEY_WIDTH-1:0]));

	logic [CW:0]   left_w, right_w;
	logic [SW-1:0] parent_w;
	assign left_w   = (CW+1)'({cur_q, 1'b1});
	assign right_w  = left_w + 1'b1;
	assign parent_w = SW'((cur_q - 1'b1) >> 1);

	logic          oth_valid_w;
	logic          r_valid_w;
	logic          use_r;
	assign oth_valid_w = key_less(oth_k_q, cur_k_q) && sts.has_left;
	assign r_valid_w   = sts.has_right;
	assign use_r = r_valid_w && key_less(r_k_q, (oth_valid_w ? oth_k_q : cur_k_q))
		&& (oth_valid_w ? 1'b1 : key_less(r_k_q, cur_k_q));

	assign sts.full      = count_q >= CW'(CAPACITY);
	assign sts.empty     = count_q == '0;
	assign sts.present   = pres_q;
	assign sts.id_ok     = id_ok_q;
	// old key sits in oth_k_q while the new key is written
	assign sts.grew      = key_less(oth_k_q, key_q);
	assign sts.up_more   = cur_q != '0;
	assign sts.up_moved  = up_mv_q;
	assign sts.dn_moved  = dn_mv_q;
	assign sts.has_left  = left_w < (CW+1)'(count_q);
	assign sts.has_right = right_w < (CW+1)'(count_q);
	assign sts.opcode    = op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			count_q   <= '0;
			status_q  <= ST_OK;
		end else begin
			if (set_status_en)
				status_q <= set_status;
			case (cmd)
				DC_PUSH_WR: begin
					present_q[NW'(id_q)] <= 1'b1;
					count_q <= count_q + 1'b1;
				end
				DC_POP_WR: begin
					present_q[rt_n_q] <= 1'b0;
					count_q <= count_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	// memory ports and working registers
	always_ff @(posedge clk) begin
		case (cmd)
			DC_LOAD_IN: begin
				op_q    <= in_item.opcode;
				id_q    <= in_item.node_id;
				key_q   <= wkey;
				id_ok_q <= 32'(in_item.node_id) < NODE_IDS;
				pres_q  <= 32'(in_item.node_id) < NODE_IDS &&
					present_q[NW'(in_item.node_id)];
				map_q   <= node_slot[NW'(in_item.node_id)];
				up_mv_q <= 1'b0;
				dn_mv_q <= 1'b0;
			end
			DC_PUSH_WR: begin
				slot_node[count_q[SW-1:0]] <= NW'(id_q);
				slot_key[count_q[SW-1:0]]  <= key_q;
				node_slot[NW'(id_q)]       <= count_q[SW-1:0];
				cur_q   <= count_q[SW-1:0];
				cur_n_q <= NW'(id_q);
				cur_k_q <= key_q;
			end
			DC_POP_RD: begin
				oth_n_q <= slot_node[SW'(count_q - 1'b1)];
				oth_k_q <= slot_key[SW'(count_q - 1'b1)];
			end
			DC_POP_WR: begin
				slot_node[0] <= oth_n_q;
				slot_key[0]  <= oth_k_q;
				node_slot[oth_n_q] <= '0;
				cur_q   <= '0;
				cur_n_q <= oth_n_q;
				cur_k_q <= oth_k_q;
			end
			DC_UPD_RD: begin
				cur_q   <= map_q;
				cur_n_q <= slot_node[map_q];
				oth_k_q <= slot_key[map_q];
			end
			DC_UPD_WR: begin
				slot_key[cur_q] <= key_q;
				cur_k_q <= key_q;
			end
			DC_UP_RD: begin
				oth_q   <= parent_w;
				oth_n_q <= slot_node[parent_w];
				oth_k_q <= slot_key[parent_w];
			end
			DC_UP_SWAP: begin
				up_mv_q <= key_less(cur_k_q, oth_k_q);
				if (key_less(cur_k_q, oth_k_q)) begin
					slot_node[oth_q] <= cur_n_q;
					slot_key[oth_q]  <= cur_k_q;
					slot_node[cur_q] <= oth_n_q;
					slot_key[cur_q]  <= oth_k_q;
					node_slot[cur_n_q] <= oth_q;
					node_slot[oth_n_q] <= cur_q;
					cur_q <= oth_q;
				end
			end
			DC_DN_RD_L: begin
				oth_q   <= SW'(left_w);
				oth_n_q <= slot_node[SW'(left_w)];
				oth_k_q <= slot_key[SW'(left_w)];
			end
			DC_DN_RD_R: begin
				r_q   <= SW'(right_w);
				r_n_q <= slot_node[SW'(right_w)];
				r_k_q <= slot_key[SW'(right_w)];
			end
			DC_DN_SWAP: begin
				dn_mv_q <= oth_valid_w || use_r;
				if (use_r) begin
					slot_node[r_q] <= cur_n_q;
					slot_key[r_q]  <= cur_k_q;
					slot_node[cur_q] <= r_n_q;
					slot_key[cur_q]  <= r_k_q;
					node_slot[cur_n_q] <= r_q;
					node_slot[r_n_q] <= cur_q;
					cur_q <= r_q;
				end else if (oth_valid_w) begin
					slot_node[oth_q] <= cur_n_q;
					slot_key[oth_q]  <= cur_k_q;
					slot_node[cur_q] <= oth_n_q;
					slot_key[cur_q]  <= oth_k_q;
					node_slot[cur_n_q] <= oth_q;
					node_slot[oth_n_q] <= cur_q;
					cur_q <= oth_q;
				end
			end
			DC_ROOT_RD: begin
				rt_n_q <= slot_node[0];
				rt_k_q <= slot_key[0];
			end
			default: ;
		endcase
	end

	assign out_item.is_empty    = count_q == '0;
	assign out_item.top_node_id = (count_q == '0) ? '0 : 6'(rt_n_q);
	assign out_item.top_key     = (count_q == '0) ? '0 : rt_k_q;
	assign out_item.node_count  = 7'(count_q);
	assign out_item.status      = status_q;

	`IMH_ASSERT(a_count_cap, clk, arst_n, count_q <= CW'(CAPACITY))
	`IMH_ASSERT_NEXT(a_push_inc, clk, arst_n, cmd == DC_PUSH_WR, count_q == $past(count_q) + 1'b1)
	`IMH_ASSERT_NEXT(a_pop_dec, clk, arst_n, cmd == DC_POP_WR, count_q == $past(count_q) - 1'b1)
endmodule

// ===== hdl/imh_ctrl.sv =====
// controller: sequences push, pop and update through the datapath
`timescale 1ns / 1ps
`include "indexed_min_heap_priority_queue_assert.svh"
module imh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  imh_pkg::imh_sts_t sts,
	output imh_pkg::imh_cmd_t cmd,
	output logic [2:0]        set_status,
	output logic              set_status_en
);
	import imh_pkg::*;
	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_PUSH, S_POP_RD, S_POP_WR, S_UPD_RD, S_UPD_WR,
		S_UP_RD, S_UP_SWAP, S_UP_CHK, S_DN_L, S_DN_R, S_DN_SWAP, S_DN_CHK, S_ROOT, S_OUT
	} state_t;
	state_t state_q;

	assign in_ready = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;

	always_comb begin
		cmd = DC_NONE;
		set_status_en = 1'b0;
		set_status = ST_OK;
		case (state_q)
			S_IDLE:    cmd = in_valid ? DC_LOAD_IN : DC_NONE;
			S_DECODE: begin
				set_status_en = 1'b1;
				case (sts.opcode)
					OP_PUSH:   set_status = sts.full ? ST_FULL : !sts.id_ok ? ST_ABSENT :
						sts.present ? ST_DUP : ST_OK;
					OP_POP:    set_status = sts.empty ? ST_EMPTY : ST_OK;
					OP_UPDATE: set_status = sts.present ? ST_OK : ST_ABSENT;
					default:   set_status = ST_OK;
				endcase
			end
			S_PUSH:    cmd = DC_PUSH_WR;
			S_POP_RD:  cmd = DC_POP_RD;
			S_POP_WR:  cmd = DC_POP_WR;
			S_UPD_RD:  cmd = DC_UPD_RD;
			S_UPD_WR:  cmd = DC_UPD_WR;
			S_UP_RD:   cmd = DC_UP_RD;
			S_UP_SWAP: cmd = DC_UP_SWAP;
			S_DN_L:    cmd = DC_DN_RD_L;
			S_DN_R:    cmd = DC_DN_RD_R;
			S_DN_SWAP: cmd = DC_DN_SWAP;
			S_ROOT:    cmd = DC_ROOT_RD;
			default:   cmd = DC_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_DECODE;
				S_DECODE: begin
					case (sts.opcode)
						OP_PUSH: state_q <= (sts.full || !sts.id_ok || sts.present) ?
							S_ROOT : S_PUSH;
						OP_POP:  state_q <= sts.empty ? S_ROOT : S_POP_RD;
						OP_UPDATE: state_q <= sts.present ? S_UPD_RD : S_ROOT;
						default: state_q <= S_ROOT;
					endcase
				end
				S_PUSH:    state_q <= S_UP_RD;
				S_POP_RD:  state_q <= S_POP_WR;
				S_POP_WR:  state_q <= S_DN_L;
				S_UPD_RD:  state_q <= S_UPD_WR;
				S_UPD_WR:  state_q <= sts.grew ? S_DN_L : S_UP_RD;
				// stop at root
				S_UP_RD:   state_q <= sts.up_more ? S_UP_SWAP : S_ROOT;
				S_UP_SWAP: state_q <= S_UP_CHK;
				S_UP_CHK:  state_q <= sts.up_moved ? S_UP_RD : S_ROOT;
				S_DN_L:    state_q <= sts.has_left ? S_DN_R : S_ROOT;
				S_DN_R:    state_q <= S_DN_SWAP;
				S_DN_SWAP: state_q <= S_DN_CHK;
				// after a down step, loop while the entry moved
				S_DN_CHK:  state_q <= sts.dn_moved ? S_DN_L : S_ROOT;
				S_ROOT:    state_q <= S_OUT;
				S_OUT:     if (out_ready) state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	`IMH_ASSERT_NEXT(a_accept_decode, clk, arst_n, in_valid && in_ready, state_q == S_DECODE)
	`IMH_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`IMH_ASSERT(a_one_side, clk, arst_n, !(in_ready && out_valid))
endmodule

// ===== hdl/indexed_min_heap_priority_queue.sv =====
// Indexed binary min-heap priority queue over signed keys. One item is taken at a
// time and answered with one result. After accept and decode, a push writes the
// new entry and a pop or an update reads, then writes; a level sifted up reads the
// parent, compares and swaps, then checks, and a level sifted down reads the left
// and right children, chooses and swaps, then checks. Reading the root and handing
// over the result end each item, straight after decode for a reject or a no-op.
// Longest for 64 slots: an update that grows the root key and sinks it six levels.
// No clearing pass after reset: only present bits, count and status are reset.
`timescale 1ns / 1ps
module indexed_min_heap_priority_queue #(
	parameter int CAPACITY  = imh_pkg::CAPACITY_DEF,
	parameter int NODE_IDS  = imh_pkg::NODE_IDS_DEF,
	parameter int KEY_WIDTH = imh_pkg::KEY_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  imh_pkg::imh_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output imh_pkg::imh_out_t out_data
);
	import imh_pkg::*;
	imh_cmd_t   cmd;
	imh_sts_t   sts;
	logic [2:0] set_status;
	logic       set_status_en;

	imh_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.sts, .cmd, .set_status, .set_status_en
	);

	imh_datapath #(.CAPACITY(CAPACITY), .NODE_IDS(NODE_IDS), .KEY_WIDTH(KEY_WIDTH)) u_dp (
		.clk, .arst_n, .in_item(in_data), .cmd, .set_status, .set_status_en,
		.sts, .out_item(out_data)
	);
endmodule
